@@ rtl/core/gwwb_pkg.sv @@
package gwwb_pkg;

   localparam int PARA_MAX = 4096;
   localparam int IDX_W = $clog2(PARA_MAX);

   localparam int CODE_W = 8;
   localparam int CW_W = 8;
   localparam int PX_W = 16;
   localparam int STEP_W = 10;
   localparam int POS_W = 12;
   localparam int REM_CNT_W = $clog2(PX_W);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [0:0] REG_WRAP_LIMIT = 1'b0;
   localparam logic [0:0] REG_TAB_STEP = 1'b1;

   localparam logic [PX_W-1:0] WRAP_LIMIT_RESET = PX_W'(576);
   localparam logic [STEP_W-1:0] TAB_STEP_RESET = STEP_W'(64);

   localparam logic [CODE_W-1:0] CHAR_TAB = CODE_W'(9);
   localparam logic [CODE_W-1:0] CHAR_NEWLINE = CODE_W'(10);
   localparam logic [CODE_W-1:0] CHAR_SPACE = CODE_W'(32);

   typedef enum logic [1:0] {
      MODE_NORMAL    = 2'd0,
      MODE_LONG_WORD = 2'd1,
      MODE_SEEK_WORD = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_REM  = 2'd1,
      ST_EVAL = 2'd2
   } state_type;

   typedef struct packed {
      logic [PX_W-1:0]   wrap_limit;
      logic [STEP_W-1:0] tab_step;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [PX_W-1:0]   dividend;
      logic [STEP_W-1:0] divisor;
   } rem_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [STEP_W-1:0] remainder;
   } rem_stat_type;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] r;
      if (idx == IDX_W'(PARA_MAX - 1)) begin
         r = '0;
      end else begin
         r = idx + IDX_W'(1);
      end
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] r;
      if (idx == '0) begin
         r = IDX_W'(PARA_MAX - 1);
      end else begin
         r = idx - IDX_W'(1);
      end
      return r;
   endfunction

endpackage

@@ rtl/core/gwwb_req_if.sv @@
interface gwwb_req_if;
   logic                           valid;
   logic                           ready;
   logic [gwwb_pkg::CODE_W-1:0]    char_code;
   logic [gwwb_pkg::CW_W-1:0]      char_width;
   logic                           is_last;

   modport source(output valid, output char_code, output char_width, output is_last,
                  input ready);
   modport sink(input valid, input char_code, input char_width, input is_last,
                output ready);
endinterface

@@ rtl/core/gwwb_rsp_if.sv @@
interface gwwb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gwwb_pkg::POS_W-1:0]     break_pos;

   modport source(output valid, output break_pos, input ready);
   modport sink(input valid, input break_pos, output ready);
endinterface

@@ rtl/core/gwwb_csr.sv @@
module gwwb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gwwb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gwwb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gwwb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output gwwb_pkg::cfg_type                 cfg
);

   logic [gwwb_pkg::PX_W-1:0]   wrap_limit_ff;
   logic [gwwb_pkg::STEP_W-1:0] tab_step_ff;
   logic                        wr_en;
   logic [0:0]                  reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel = csr_paddr[gwwb_pkg::CSR_ADDR_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_limit_ff <= gwwb_pkg::WRAP_LIMIT_RESET;
         tab_step_ff <= gwwb_pkg::TAB_STEP_RESET;
      end else if (wr_en) begin
         if (reg_sel == gwwb_pkg::REG_WRAP_LIMIT) begin
            wrap_limit_ff <= csr_pwdata[gwwb_pkg::PX_W-1:0];
         end else begin
            tab_step_ff <= csr_pwdata[gwwb_pkg::STEP_W-1:0];
         end
      end
   end

   always_comb begin
      if (reg_sel == gwwb_pkg::REG_WRAP_LIMIT) begin
         csr_prdata = gwwb_pkg::CSR_DATA_W'(wrap_limit_ff);
      end else begin
         csr_prdata = gwwb_pkg::CSR_DATA_W'(tab_step_ff);
      end
   end

   assign cfg.wrap_limit = wrap_limit_ff;
   assign cfg.tab_step = tab_step_ff;

endmodule

@@ rtl/core/gwwb_rem.sv @@
module gwwb_rem (
   input  logic                   clock,
   input  logic                   reset,
   input  gwwb_pkg::rem_ctrl_type ctrl,
   output gwwb_pkg::rem_stat_type stat
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [gwwb_pkg::REM_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [gwwb_pkg::PX_W-1:0]        dvd_ff, dvd_in;
   logic [gwwb_pkg::STEP_W-1:0]      dsr_ff, dsr_in;
   logic [gwwb_pkg::STEP_W-1:0]      rem_ff, rem_in;
   logic [gwwb_pkg::STEP_W:0]        trial;

   assign trial = {rem_ff, dvd_ff[gwwb_pkg::PX_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      rem_in = rem_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         dvd_in = ctrl.dividend;
         dsr_in = ctrl.divisor;
         rem_in = '0;
      end else if (busy_ff) begin
         // restore-or-subtract, one dividend bit per cycle
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = gwwb_pkg::STEP_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = gwwb_pkg::STEP_W'(trial);
         end
         dvd_in = {dvd_ff[gwwb_pkg::PX_W-2:0], 1'b0};
         cnt_in = cnt_ff + gwwb_pkg::REM_CNT_W'(1);
         if (cnt_ff == gwwb_pkg::REM_CNT_W'(gwwb_pkg::PX_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign stat.done = done_ff;
   assign stat.remainder = rem_ff;

endmodule

@@ rtl/core/gwwb_core.sv @@
module gwwb_core (
   input  logic                   clock,
   input  logic                   reset,
   input  gwwb_pkg::cfg_type      cfg,
   gwwb_req_if.sink               req,
   gwwb_rsp_if.source             rsp,
   output gwwb_pkg::rem_ctrl_type rem_ctrl,
   input  gwwb_pkg::rem_stat_type rem_stat
);

   localparam int PX_W = gwwb_pkg::PX_W;
   localparam int IDX_W = gwwb_pkg::IDX_W;

   gwwb_pkg::state_type           state_ff, state_in;
   gwwb_pkg::mode_type            mode_ff, mode_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [PX_W-1:0]               line_px_ff, line_px_in;
   logic [IDX_W-1:0]              word_begin_ff, word_begin_in;
   logic [PX_W-1:0]               word_px_ff, word_px_in;
   logic                          prev_blank_ff, prev_blank_in;
   logic                          opens_ff, opens_in;

   logic [gwwb_pkg::CODE_W-1:0]   code_ff;
   logic [gwwb_pkg::CW_W-1:0]     width_ff;
   logic                          last_ff;

   logic                          rsp_valid_ff;
   logic [gwwb_pkg::POS_W-1:0]    break_pos_ff;

   logic [gwwb_pkg::STEP_W-1:0]   step;
   logic                          is_tab, blank, need_rem, commit;
   logic                          brk_valid;
   logic [IDX_W-1:0]              brk_idx;
   logic [IDX_W-1:0]              wb_eff;
   logic [PX_W-1:0]               wpx_eff, ol_prior;
   logic [PX_W:0]                 adv, sum, ol_px;
   logic                          over, ol_over;

   assign step = (cfg.tab_step == '0) ? gwwb_pkg::STEP_W'(1) : cfg.tab_step;
   assign is_tab = (code_ff == gwwb_pkg::CHAR_TAB);
   assign blank = is_tab || (code_ff == gwwb_pkg::CHAR_SPACE) ||
                  (code_ff == gwwb_pkg::CHAR_NEWLINE);
   assign need_rem = (req.char_code == gwwb_pkg::CHAR_TAB) &&
                     (mode_ff != gwwb_pkg::MODE_LONG_WORD) &&
                     (mode_ff != gwwb_pkg::MODE_SEEK_WORD);

   assign adv = is_tab ? (PX_W + 1)'(step - rem_stat.remainder) : (PX_W + 1)'(width_ff);
   assign sum = {1'b0, line_px_ff} + adv;
   assign over = sum > {1'b0, cfg.wrap_limit};

   assign wb_eff = prev_blank_ff ? idx_ff : word_begin_ff;
   assign wpx_eff = prev_blank_ff ? '0 : word_px_ff;
   assign ol_prior = (mode_ff == gwwb_pkg::MODE_SEEK_WORD) ? '0 : wpx_eff;
   assign ol_px = {1'b0, ol_prior} + (PX_W + 1)'(width_ff);
   assign ol_over = ol_px > {1'b0, cfg.wrap_limit};

   always_comb begin
      mode_in = mode_ff;
      line_px_in = line_px_ff;
      word_begin_in = word_begin_ff;
      word_px_in = word_px_ff;
      opens_in = opens_ff;
      brk_valid = 1'b0;
      brk_idx = gwwb_pkg::idx_dec(wb_eff);
      case (mode_ff)
         gwwb_pkg::MODE_LONG_WORD: begin
            if (blank) begin
               mode_in = gwwb_pkg::MODE_SEEK_WORD;
            end
         end
         gwwb_pkg::MODE_SEEK_WORD: begin
            if (!blank) begin
               brk_valid = 1'b1;
               brk_idx = gwwb_pkg::idx_dec(idx_ff);
               word_begin_in = idx_ff;
               opens_in = 1'b1;
               if (ol_over) begin
                  mode_in = gwwb_pkg::MODE_LONG_WORD;
               end else begin
                  line_px_in = ol_px[PX_W-1:0];
                  word_px_in = ol_px[PX_W-1:0];
                  mode_in = gwwb_pkg::MODE_NORMAL;
               end
            end
         end
         default: begin
            if (blank) begin
               if (over) begin
                  mode_in = gwwb_pkg::MODE_SEEK_WORD;
               end else begin
                  line_px_in = sum[PX_W-1:0];
               end
               opens_in = 1'b0;
            end else begin
               word_begin_in = wb_eff;
               word_px_in = wpx_eff;
               if (!over) begin
                  line_px_in = sum[PX_W-1:0];
                  word_px_in = wpx_eff + PX_W'(width_ff);
               end else if (opens_ff) begin
                  mode_in = gwwb_pkg::MODE_LONG_WORD;
               end else begin
                  brk_valid = 1'b1;
                  opens_in = 1'b1;
                  if (ol_over) begin
                     mode_in = gwwb_pkg::MODE_LONG_WORD;
                  end else begin
                     line_px_in = ol_px[PX_W-1:0];
                     word_px_in = ol_px[PX_W-1:0];
                     mode_in = gwwb_pkg::MODE_NORMAL;
                  end
               end
            end
         end
      endcase
      prev_blank_in = blank;
      idx_in = gwwb_pkg::idx_inc(idx_ff);
      if (last_ff) begin
         idx_in = '0;
         line_px_in = '0;
         word_begin_in = '0;
         word_px_in = '0;
         mode_in = gwwb_pkg::MODE_NORMAL;
         prev_blank_in = 1'b1;
         opens_in = 1'b1;
      end
   end

   // hold the update while a new break would overwrite an untaken one
   assign commit = (state_ff == gwwb_pkg::ST_EVAL) &&
                   (!brk_valid || !rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gwwb_pkg::ST_IDLE: begin
            if (req.valid) begin
               state_in = need_rem ? gwwb_pkg::ST_REM : gwwb_pkg::ST_EVAL;
            end
         end
         gwwb_pkg::ST_REM: begin
            if (rem_stat.done) begin
               state_in = gwwb_pkg::ST_EVAL;
            end
         end
         gwwb_pkg::ST_EVAL: begin
            if (commit) begin
               state_in = gwwb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gwwb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req.ready = (state_ff == gwwb_pkg::ST_IDLE);
      rem_ctrl.start = (state_ff == gwwb_pkg::ST_IDLE) && req.valid && need_rem;
      rem_ctrl.dividend = line_px_ff;
      rem_ctrl.divisor = step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gwwb_pkg::ST_IDLE;
         mode_ff <= gwwb_pkg::MODE_NORMAL;
         idx_ff <= '0;
         line_px_ff <= '0;
         word_begin_ff <= '0;
         word_px_ff <= '0;
         prev_blank_ff <= 1'b1;
         opens_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            mode_ff <= mode_in;
            idx_ff <= idx_in;
            line_px_ff <= line_px_in;
            word_begin_ff <= word_begin_in;
            word_px_ff <= word_px_in;
            prev_blank_ff <= prev_blank_in;
            opens_ff <= opens_in;
         end
         if (commit && brk_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req.valid && req.ready) begin
         code_ff <= req.char_code;
         width_ff <= req.char_width;
         last_ff <= req.is_last;
      end
      if (commit && brk_valid) begin
         break_pos_ff <= gwwb_pkg::POS_W'(brk_idx);
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.break_pos = break_pos_ff;

endmodule

@@ rtl/core/greedy_word_wrap_breaker_top.sv @@
// Greedy word-wrap break finder: one paragraph byte per req transfer, at most one
// break position per byte on rsp, held in an output register so the next byte can
// be taken while a break waits. A tab on a line that is still being filled waits for
// the bit-serial remainder unit that rounds the line position to the next tab stop
// (one dividend bit per cycle, 16 bits). A byte whose break finds the previous
// break still untaken holds until rsp transfers it. The state clears after the byte
// marked is_last. Write wrap_limit (offset 0) and tab_step (offset 4) only while
// the block is idle.
module greedy_word_wrap_breaker_top (
   input  logic                              clock,
   input  logic                              reset,
   gwwb_req_if.sink                          req,
   gwwb_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gwwb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gwwb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gwwb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   gwwb_pkg::cfg_type      cfg;
   gwwb_pkg::rem_ctrl_type rem_ctrl;
   gwwb_pkg::rem_stat_type rem_stat;

   gwwb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gwwb_rem u_rem (
      .clock (clock),
      .reset (reset),
      .ctrl  (rem_ctrl),
      .stat  (rem_stat)
   );

   gwwb_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req      (req),
      .rsp      (rsp),
      .rem_ctrl (rem_ctrl),
      .rem_stat (rem_stat)
   );

endmodule

@@ bench/greedy_word_wrap_breaker_top_test.sv @@
module greedy_word_wrap_breaker_top_test;
   import gwwb_pkg::*;

   localparam int unsigned TIMEOUT_CYCLES = 3_000_000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [CODE_W-1:0] code;
      logic [CW_W-1:0]   px;
      logic              last;
   } glyph_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   gwwb_req_if char_ch();
   gwwb_rsp_if brk_ch();

   greedy_word_wrap_breaker_top i_dut (
      .clock(clock),
      .reset(reset),
      .req(char_ch),
      .rsp(brk_ch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   glyph_type           pending_chars[$];
   logic [POS_W-1:0]    pending_breaks[$];
   glyph_type           on_bus;
   int                  err_cnt = 0;
   int                  send_gap = 0;
   int                  send_calm = 0;
   int                  rsp_stall = 0;
   int                  rsp_calm = 0;
   int unsigned         cycle_cnt = 0;

   // line-breaking state and configuration mirrored from the block
   logic [PX_W-1:0]     lim_px;
   logic [STEP_W-1:0]   stop_px;
   mode_type            wrap_st;
   logic [IDX_W-1:0]    next_idx;
   logic [IDX_W-1:0]    word_idx;
   logic [PX_W-1:0]     pos_px;
   logic [PX_W-1:0]     run_px;
   bit                  after_blank;
   bit                  word_leads;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_err(input string msg);
      err_cnt++;
      if (err_cnt <= 100) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
   endtask

   function automatic void clear_para();
      next_idx = '0;
      pos_px = '0;
      word_idx = '0;
      run_px = '0;
      wrap_st = MODE_NORMAL;
      after_blank = 1'b1;
      word_leads = 1'b1;
   endfunction

   function automatic void start_line(input int unsigned prior, input int unsigned w);
      int unsigned px;
      px = prior + w;
      word_leads = 1'b1;
      if (px > lim_px) begin
         wrap_st = MODE_LONG_WORD;
      end else begin
         pos_px = PX_W'(px);
         run_px = PX_W'(px);
         wrap_st = MODE_NORMAL;
      end
   endfunction

   function automatic bit wrap_char(input glyph_type g, output logic [POS_W-1:0] brk);
      bit               tab;
      bit               blank;
      bit               hit;
      int unsigned      step;
      int unsigned      nxt;
      logic [IDX_W-1:0] idx;
      tab = (g.code == CHAR_TAB);
      blank = tab || g.code == CHAR_SPACE || g.code == CHAR_NEWLINE;
      idx = next_idx;
      hit = 1'b0;
      brk = '0;
      case (wrap_st)
         MODE_LONG_WORD: begin
            if (blank) wrap_st = MODE_SEEK_WORD;
         end
         MODE_SEEK_WORD: begin
            if (!blank) begin
               hit = 1'b1;
               brk = POS_W'(idx - 1'b1);
               word_idx = idx;
               start_line(0, g.px);
            end
         end
         default: begin
            if (blank) begin
               step = (stop_px == '0) ? 1 : stop_px;
               nxt = tab ? pos_px + step - pos_px % step : pos_px + g.px;
               if (nxt > lim_px) begin
                  wrap_st = MODE_SEEK_WORD;
               end else begin
                  pos_px = PX_W'(nxt);
               end
               word_leads = 1'b0;
            end else begin
               if (after_blank) begin
                  word_idx = idx;
                  run_px = '0;
               end
               nxt = pos_px + g.px;
               if (nxt <= lim_px) begin
                  pos_px = PX_W'(nxt);
                  run_px = run_px + g.px;
               end else if (word_leads) begin
                  wrap_st = MODE_LONG_WORD;
               end else begin
                  hit = 1'b1;
                  brk = POS_W'(word_idx - 1'b1);
                  start_line(run_px, g.px);
               end
            end
         end
      endcase
      after_blank = blank;
      next_idx = idx + 1'b1;
      if (g.last) clear_para();
      return hit;
   endfunction

   function automatic int pick_gap(inout int calm_n);
      int r;
      if (calm_n > 0) begin
         calm_n--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r == 0) begin
         calm_n = $urandom_range(30, 120);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CW_W-1:0] pick_width(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return CW_W'($urandom_range(0, 255));
      return CW_W'($urandom_range(lo, hi));
   endfunction

   function automatic logic [CODE_W-1:0] blank_char();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return CHAR_SPACE;
      if (r < 8) return CHAR_TAB;
      return CHAR_NEWLINE;
   endfunction

   function automatic void push_char(input logic [CODE_W-1:0] code,
                                     input logic [CW_W-1:0] px, input logic last);
      glyph_type g;
      g.code = code;
      g.px = px;
      g.last = last;
      pending_chars.push_back(g);
   endfunction

   task automatic add_text(input int n, input bit close, input int lo, input int hi);
      int k;
      int wl;
      k = 0;
      while (k < n) begin
         wl = $urandom_range(1, 12);
         while (wl > 0 && k < n) begin
            push_char(($urandom_range(0, 7) == 0) ? CODE_W'($urandom_range(128, 255))
                                                  : CODE_W'($urandom_range(33, 126)),
                      pick_width(lo, hi), 1'b0);
            wl--;
            k++;
         end
         wl = ($urandom_range(0, 4) == 0) ? 2 : 1;
         while (wl > 0 && k < n) begin
            push_char(blank_char(), pick_width(lo, hi), 1'b0);
            wl--;
            k++;
         end
      end
      if (close) pending_chars[pending_chars.size()-1].last = 1'b1;
   endtask

   task automatic settle(input bit pad);
      @(negedge clock);
      while (pending_chars.size() != 0 || char_ch.valid || pending_breaks.size() != 0) begin
         @(negedge clock);
      end
      if (pad) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] reg_id, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] want;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({reg_id, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_id == REG_WRAP_LIMIT) begin
         lim_px = value[PX_W-1:0];
         want = CSR_DATA_W'(lim_px);
      end else begin
         stop_px = value[STEP_W-1:0];
         want = CSR_DATA_W'(stop_px);
      end
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         report_err($sformatf("register %0d reads %0h, expected %0h", reg_id, csr_prdata, want));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_cfg(input logic [PX_W-1:0] lim, input logic [STEP_W-1:0] stop);
      settle(1'b1);
      write_reg(REG_WRAP_LIMIT, CSR_DATA_W'(lim));
      write_reg(REG_TAB_STEP, CSR_DATA_W'(stop));
   endtask

   always @(posedge clock) begin : send_chars
      logic             nxt_valid;
      logic [POS_W-1:0] bpos;
      if (reset) begin
         char_ch.valid <= 1'b0;
      end else begin
         nxt_valid = char_ch.valid;
         if (char_ch.valid && char_ch.ready) begin
            if (wrap_char(on_bus, bpos)) pending_breaks.push_back(bpos);
            nxt_valid = 1'b0;
            send_gap = pick_gap(send_calm);
         end
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_chars.size() > 0) begin
               on_bus = pending_chars.pop_front();
               char_ch.char_code <= on_bus.code;
               char_ch.char_width <= on_bus.px;
               char_ch.is_last <= on_bus.last;
               nxt_valid = 1'b1;
            end
         end
         char_ch.valid <= nxt_valid;
      end
   end

   always @(posedge clock) begin : take_breaks
      logic [POS_W-1:0] want;
      if (reset) begin
         brk_ch.ready <= 1'b0;
      end else begin
         if (brk_ch.valid && brk_ch.ready) begin
            if (pending_breaks.size() == 0) begin
               report_err($sformatf("break_pos %0d with none expected", brk_ch.break_pos));
            end else begin
               want = pending_breaks.pop_front();
               if (brk_ch.break_pos !== want) begin
                  report_err($sformatf("break_pos %0d, expected %0d", brk_ch.break_pos, want));
               end
            end
            rsp_stall = pick_gap(rsp_calm);
         end else if (!brk_ch.valid && rsp_stall == 0 && $urandom_range(0, 7) == 0) begin
            rsp_stall = pick_gap(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            brk_ch.ready <= 1'b0;
         end else begin
            brk_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_cnt < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("greedy_word_wrap_breaker_top_test: done, errors");
      $finish;
   end

   initial begin
      reset = 1'b1;
      char_ch.valid = 1'b0;
      char_ch.char_code = '0;
      char_ch.char_width = '0;
      char_ch.is_last = 1'b0;
      brk_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      lim_px = WRAP_LIMIT_RESET;
      stop_px = TAB_STEP_RESET;
      clear_para();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // fill a line, tab stop, word opening its line, overflow on a blank
      set_cfg(16'd20, 10'd8);
      push_char("a", 8'd5, 1'b0);
      push_char("b", 8'd5, 1'b0);
      push_char(CHAR_SPACE, 8'd5, 1'b0);
      push_char("c", 8'd5, 1'b0);
      push_char("d", 8'd5, 1'b0);
      push_char(CHAR_TAB, 8'd0, 1'b0);
      push_char("e", 8'd8, 1'b0);
      push_char("f", 8'd8, 1'b0);
      push_char("g", 8'd8, 1'b0);
      push_char("h", 8'd255, 1'b0);
      push_char(CHAR_NEWLINE, 8'd3, 1'b0);
      push_char(8'h00, 8'd255, 1'b0);
      push_char(CHAR_SPACE, 8'd0, 1'b0);
      push_char(8'hff, 8'd0, 1'b0);
      push_char(CHAR_SPACE, 8'd30, 1'b0);
      push_char("z", 8'd4, 1'b1);

      // tab step of zero acts as one, on the narrowest line
      set_cfg(16'd2, 10'd0);
      push_char(CHAR_TAB, 8'd0, 1'b0);
      push_char(CHAR_TAB, 8'd0, 1'b0);
      push_char(CHAR_TAB, 8'd0, 1'b0);
      push_char("q", 8'd1, 1'b0);
      push_char("r", 8'd2, 1'b1);

      set_cfg(WRAP_LIMIT_RESET, TAB_STEP_RESET);
      add_text(100, 1'b0, 4, 16);
      settle(1'b0);
      add_text(100, 1'b1, 4, 16);

      set_cfg(16'd65535, 10'd1023);
      add_text(150, 1'b1, 150, 255);

      set_cfg(16'd2, 10'd1);
      add_text(80, 1'b1, 0, 3);

      set_cfg(16'd100, 10'd7);
      add_text(150, 1'b1, 3, 12);

      set_cfg(16'd300, 10'd37);
      add_text(150, 1'b1, 2, 10);

      set_cfg(16'd300, STEP_W'($urandom_range(1, 1023)));
      repeat (100) begin
         push_char(($urandom_range(0, 3) == 0) ? blank_char() : CODE_W'($urandom_range(0, 255)),
                   CW_W'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
      end

      repeat (3) begin
         set_cfg(PX_W'($urandom_range(40, 800)), STEP_W'($urandom_range(1, 1023)));
         add_text(50, 1'b1, 2, 20);
      end

      settle(1'b1);
      if (err_cnt == 0) begin
         $display("greedy_word_wrap_breaker_top_test: done, clean");
      end else begin
         $display("greedy_word_wrap_breaker_top_test: done, errors");
      end
      $finish;
   end

endmodule
